// ===== design/ppu_pkg.sv =====
// Shared types, codes, tables and saturation helpers for the particle update pipeline.
`default_nettype none

package ppu_pkg;

  // Particle type codes
  typedef logic [2:0] ptype_t;
  localparam ptype_t PTYPE_STATIC   = 3'd0;
  localparam ptype_t PTYPE_GRAV     = 3'd1;
  localparam ptype_t PTYPE_SLOWGRAV = 3'd2;
  localparam ptype_t PTYPE_FIRE     = 3'd3;
  localparam ptype_t PTYPE_EXPLODE  = 3'd4;
  localparam ptype_t PTYPE_EXPLODE2 = 3'd5;
  localparam ptype_t PTYPE_BLOB     = 3'd6;
  localparam ptype_t PTYPE_BLOB2    = 3'd7;

  // Configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_NOW_TIME   = 1'b0;
  localparam cfg_idx_t CFG_FRAME_TIME = 1'b1;

  // Fixed-point constants
  localparam int unsigned GRAV_PER_SEC = 40;        // gravity, units per second^2
  localparam logic [15:0] RAMP_LIMIT_FIRE = 16'h6000; // 6.0 in Q4.12
  localparam logic [15:0] RAMP_LIMIT_EXPL = 16'h8000; // 8.0 in Q4.12

  typedef struct packed {
    ptype_t              particle_type;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  pos_z;
    logic signed [31:0]  vel_x;
    logic signed [31:0]  vel_y;
    logic signed [31:0]  vel_z;
    logic [15:0]         ramp_pos;
    logic [31:0]         die_time;
    logic [7:0]          palette_index;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic                keep;
    ptype_t              out_type;
    logic signed [31:0]  new_pos_x;
    logic signed [31:0]  new_pos_y;
    logic signed [31:0]  new_pos_z;
    logic signed [31:0]  new_vel_x;
    logic signed [31:0]  new_vel_y;
    logic signed [31:0]  new_vel_z;
    logic [15:0]         new_ramp;
    logic [31:0]         new_die_time;
    logic [7:0]          new_color;
    logic                out_last;
  } out_item_t;

  // After the multiply stage: raw products of velocity and frame time
  typedef struct packed {
    in_item_t            item;
    logic                alive;
    logic signed [47:0]  prod_x;
    logic signed [47:0]  prod_y;
    logic signed [47:0]  prod_z;
    logic [13:0]         grav;
    logic [15:0]         step;
  } s1_t;

  // After the rounding stage: rounded deltas, velocity adjustments, ramp result
  typedef struct packed {
    in_item_t            item;
    logic                alive;
    logic signed [32:0]  delta_x;
    logic signed [32:0]  delta_y;
    logic signed [32:0]  delta_z;
    logic signed [34:0]  adj_x;
    logic signed [34:0]  adj_y;
    logic signed [34:0]  adj_z;
    logic signed [14:0]  grav_z;
    logic [15:0]         ramp;
    logic [31:0]         die_time;
    logic [7:0]          color;
  } s2_t;

  // Ramp speed in multiples of frame time; zero for types without a ramp
  function automatic logic [3:0] ramp_rate(input ptype_t t);
    logic [3:0] k;
    unique case (t)
      PTYPE_FIRE:     k = 4'd5;
      PTYPE_EXPLODE:  k = 4'd10;
      PTYPE_EXPLODE2: k = 4'd15;
      default:        k = 4'd0;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] ramp_limit(input ptype_t t);
    logic [15:0] lim;
    unique case (t)
      PTYPE_FIRE: lim = RAMP_LIMIT_FIRE;
      default:    lim = RAMP_LIMIT_EXPL;
    endcase
    return lim;
  endfunction

  // Color ramp tables, indexed by the integer part of the ramp
  function automatic logic [7:0] ramp_color(input ptype_t t, input logic [2:0] idx);
    logic [7:0] c;
    unique case (t)
      PTYPE_FIRE: begin
        unique case (idx)
          3'd0: c = 8'h6d;
          3'd1: c = 8'h6b;
          3'd2: c = 8'h06;
          3'd3: c = 8'h05;
          3'd4: c = 8'h04;
          3'd5: c = 8'h03;
          default: c = 8'h00;
        endcase
      end
      PTYPE_EXPLODE2: begin
        unique case (idx)
          3'd0: c = 8'h6f;
          3'd1: c = 8'h6e;
          3'd2: c = 8'h6d;
          3'd3: c = 8'h6c;
          3'd4: c = 8'h6b;
          3'd5: c = 8'h6a;
          3'd6: c = 8'h68;
          default: c = 8'h66;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0: c = 8'h6f;
          3'd1: c = 8'h6d;
          3'd2: c = 8'h6b;
          3'd3: c = 8'h69;
          3'd4: c = 8'h67;
          3'd5: c = 8'h65;
          3'd6: c = 8'h63;
          default: c = 8'h61;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat_pos(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_vel(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/ppu_mul_stage.sv =====
// First pipeline stage: velocity-by-frame-time products, gravity, ramp step, death test.
`default_nettype none

module ppu_mul_stage (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              up_valid,
  output logic             up_stall,
  input  ppu_pkg::in_item_t up_item,
  input  wire [31:0]       now_time,
  input  wire [15:0]       frame_time,
  output logic             dn_valid,
  input  wire              dn_stall,
  output ppu_pkg::s1_t     dn_data
);

  logic              valid_r;
  ppu_pkg::s1_t      data_r;
  ppu_pkg::s1_t      data_nxt;
  logic signed [16:0] ft_s;
  logic [21:0]       g40;
  logic [19:0]       kf;

  assign up_stall = valid_r & dn_stall;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Products and per-frame constants
  always_comb begin
    ft_s = $signed({1'b0, frame_time});
    g40  = 22'(frame_time) * 22'(ppu_pkg::GRAV_PER_SEC) + 22'd128;
    kf   = 20'(ppu_pkg::ramp_rate(up_item.particle_type)) * 20'(frame_time) + 20'd8;
    data_nxt.item   = up_item;
    data_nxt.alive  = up_item.die_time > now_time;
    data_nxt.prod_x = up_item.vel_x * ft_s;
    data_nxt.prod_y = up_item.vel_y * ft_s;
    data_nxt.prod_z = up_item.vel_z * ft_s;
    data_nxt.grav   = g40[21:8];
    data_nxt.step   = kf[19:4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/ppu_round_stage.sv =====
// Second pipeline stage: rounding of products, per-type velocity terms, color ramp.
`default_nettype none

module ppu_round_stage (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          up_valid,
  output logic         up_stall,
  input  ppu_pkg::s1_t up_data,
  output logic         dn_valid,
  input  wire          dn_stall,
  output ppu_pkg::s2_t dn_data
);

  logic               valid_r;
  ppu_pkg::s2_t       data_r;
  ppu_pkg::s2_t       data_nxt;
  logic signed [48:0] p16_x, p16_y, p16_z;
  logic signed [48:0] p14_x, p14_y, p14_z;
  logic signed [34:0] t14_x, t14_y, t14_z;
  logic signed [34:0] g_ext;
  logic [16:0]        ramp_sum;
  logic [15:0]        ramp_sat;
  ppu_pkg::ptype_t    ptype;

  assign up_stall = valid_r & dn_stall;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Round half up: add half an LSB, then drop the low bits (floor)
  always_comb begin
    p16_x = 49'(up_data.prod_x) + 49'sd32768;
    p16_y = 49'(up_data.prod_y) + 49'sd32768;
    p16_z = 49'(up_data.prod_z) + 49'sd32768;
    p14_x = 49'(up_data.prod_x) + 49'sd8192;
    p14_y = 49'(up_data.prod_y) + 49'sd8192;
    p14_z = 49'(up_data.prod_z) + 49'sd8192;
    t14_x = p14_x[48:14];
    t14_y = p14_y[48:14];
    t14_z = p14_z[48:14];
  end

  // Velocity terms and gravity by type, then the color ramp
  always_comb begin
    ptype = up_data.item.particle_type;
    g_ext = 35'(up_data.grav);
    data_nxt.item    = up_data.item;
    data_nxt.alive   = up_data.alive;
    data_nxt.delta_x = p16_x[48:16];
    data_nxt.delta_y = p16_y[48:16];
    data_nxt.delta_z = p16_z[48:16];
    data_nxt.adj_x   = '0;
    data_nxt.adj_y   = '0;
    data_nxt.adj_z   = '0;
    unique case (ptype)
      ppu_pkg::PTYPE_EXPLODE, ppu_pkg::PTYPE_BLOB: begin
        data_nxt.adj_x = t14_x;
        data_nxt.adj_y = t14_y;
        data_nxt.adj_z = t14_z;
      end
      ppu_pkg::PTYPE_EXPLODE2: begin
        data_nxt.adj_x = -35'($signed(p16_x[48:16]));
        data_nxt.adj_y = -35'($signed(p16_y[48:16]));
        data_nxt.adj_z = -35'($signed(p16_z[48:16]));
      end
      ppu_pkg::PTYPE_BLOB2: begin
        data_nxt.adj_x = -t14_x;
        data_nxt.adj_y = -t14_y;
      end
      default: begin
      end
    endcase
    unique case (ptype)
      ppu_pkg::PTYPE_STATIC: data_nxt.grav_z = '0;
      ppu_pkg::PTYPE_FIRE:   data_nxt.grav_z = 15'(g_ext);
      default:               data_nxt.grav_z = -15'(g_ext);
    endcase

    // Ramp advance, saturation, end of ramp and color lookup
    ramp_sum = 17'(up_data.item.ramp_pos) + 17'(up_data.step);
    ramp_sat = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
    data_nxt.ramp     = up_data.item.ramp_pos;
    data_nxt.die_time = up_data.item.die_time;
    data_nxt.color    = up_data.item.palette_index;
    if (ppu_pkg::ramp_rate(ptype) != 4'd0) begin
      data_nxt.ramp = ramp_sat;
      if (ramp_sat >= ppu_pkg::ramp_limit(ptype)) begin
        data_nxt.die_time = '0;
      end else begin
        data_nxt.color = ppu_pkg::ramp_color(ptype, ramp_sat[14:12]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/ppu_sum_stage.sv =====
// Third pipeline stage: saturating position and velocity sums into the output register.
`default_nettype none

module ppu_sum_stage (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                up_valid,
  output logic               up_stall,
  input  ppu_pkg::s2_t       up_data,
  output logic               dn_valid,
  input  wire                dn_stall,
  output ppu_pkg::out_item_t dn_item
);

  logic               valid_r;
  ppu_pkg::out_item_t item_r;
  ppu_pkg::out_item_t item_nxt;
  ppu_pkg::in_item_t  src;

  assign up_stall = valid_r & dn_stall;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  // Final sums, or a plain copy for a dropped particle
  always_comb begin
    src = up_data.item;
    item_nxt.out_type = src.particle_type;
    item_nxt.out_last = src.last;
    if (up_data.alive) begin
      item_nxt.keep      = 1'b1;
      item_nxt.new_pos_x = ppu_pkg::sat_pos(34'(src.pos_x) + 34'(up_data.delta_x));
      item_nxt.new_pos_y = ppu_pkg::sat_pos(34'(src.pos_y) + 34'(up_data.delta_y));
      item_nxt.new_pos_z = ppu_pkg::sat_pos(34'(src.pos_z) + 34'(up_data.delta_z));
      item_nxt.new_vel_x = ppu_pkg::sat_vel(36'(src.vel_x) + 36'(up_data.adj_x));
      item_nxt.new_vel_y = ppu_pkg::sat_vel(36'(src.vel_y) + 36'(up_data.adj_y));
      item_nxt.new_vel_z = ppu_pkg::sat_vel(36'(src.vel_z) + 36'(up_data.adj_z)
                                            + 36'(up_data.grav_z));
      item_nxt.new_ramp     = up_data.ramp;
      item_nxt.new_die_time = up_data.die_time;
      item_nxt.new_color    = up_data.color;
    end else begin
      item_nxt.keep         = 1'b0;
      item_nxt.new_pos_x    = src.pos_x;
      item_nxt.new_pos_y    = src.pos_y;
      item_nxt.new_pos_z    = src.pos_z;
      item_nxt.new_vel_x    = src.vel_x;
      item_nxt.new_vel_y    = src.vel_y;
      item_nxt.new_vel_z    = src.vel_z;
      item_nxt.new_ramp     = src.ramp_pos;
      item_nxt.new_die_time = src.die_time;
      item_nxt.new_color    = src.palette_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/particle_physics_update_core.sv =====
// Top level of the particle frame update pipeline with its configuration registers.
`default_nettype none

// Advances one particle per transfer by one frame: drops it when its die time is at or
// before now_time, otherwise moves it by frame_time times its velocity and applies its
// type rule (color ramp, velocity growth or damping, gravity) with rounding and
// saturation. Three register stages (multiply, round and ramp, saturating sums, the last
// being the output register) lie between an input transfer and a valid result, and a
// new particle is taken every cycle while the result side takes transfers. Each stage
// holds its item while the next one is stalled and empty stages fill up, so in_stall
// rises only when all three stages are occupied and out_stall is high. now_time and
// frame_time are to be written through the cfg_ port only while no particle is in
// flight; the block itself does not enforce this.
module particle_physics_update_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  ppu_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  wire                out_stall,
  output ppu_pkg::out_item_t out_item,
  input  wire                cfg_we,
  input  ppu_pkg::cfg_idx_t  cfg_index,
  input  wire [31:0]         cfg_wdata
);

  logic [31:0]  now_time_r;
  logic [15:0]  frame_time_r;
  logic         s1_valid, s1_stall;
  logic         s2_valid, s2_stall;
  ppu_pkg::s1_t s1_data;
  ppu_pkg::s2_t s2_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_time_r   <= '0;
      frame_time_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppu_pkg::CFG_NOW_TIME:   now_time_r   <= cfg_wdata;
        ppu_pkg::CFG_FRAME_TIME: frame_time_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  ppu_mul_stage u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_stall   (in_stall),
    .up_item    (in_item),
    .now_time   (now_time_r),
    .frame_time (frame_time_r),
    .dn_valid   (s1_valid),
    .dn_stall   (s1_stall),
    .dn_data    (s1_data)
  );

  ppu_round_stage u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_stall (s1_stall),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_stall (s2_stall),
    .dn_data  (s2_data)
  );

  ppu_sum_stage u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_stall (s2_stall),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== design/ppu_checker.sv =====
// Port-level checks for the particle update pipeline, bound to the top level.
`default_nettype none

module ppu_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input ppu_pkg::in_item_t  in_item,
  input wire                out_valid,
  input wire                out_stall,
  input ppu_pkg::out_item_t out_item
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result changed");

  // Back-pressure on the input only comes from back-pressure on the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall)
    else $error("input stalled while output side is free");

  // Only ramped types are killed by their ramp while kept
  a_ramp_kill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.keep && (out_item.new_die_time == 32'd0) |->
      (out_item.out_type == ppu_pkg::PTYPE_FIRE) ||
      (out_item.out_type == ppu_pkg::PTYPE_EXPLODE) ||
      (out_item.out_type == ppu_pkg::PTYPE_EXPLODE2))
    else $error("ramp end reported for a type without a ramp");

  // An input transfer never carries a particle type with unknown bits
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !$isunknown(in_item.particle_type))
    else $error("input particle type unknown at transfer");

endmodule

bind particle_physics_update_core ppu_checker u_ppu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
